// File: hw/rtl/tbbs_pkg.sv
// Shared types, codes and constants for the timed boundary brake sequencer.
// No dependencies; every module of the block imports this package.

package tbbs_pkg;

   // Field widths
   localparam int COORD_W   = 16;
   localparam int AXIS_W    = 15;
   localparam int TICK_W    = 16;
   localparam int DIST_W    = 16;
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SUM_W     = 63;
   localparam int CODE_W    = 2;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REQ_DW    = 32;
   localparam int RSP_DW    = 8;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Register map, index = byte address / 4
   typedef enum logic [2:0] {
      REG_CENTER_X      = 3'd0,
      REG_CENTER_Y      = 3'd1,
      REG_SEMI_AXIS_X   = 3'd2,
      REG_SEMI_AXIS_Y   = 3'd3,
      REG_BRAKE_TICKS   = 3'd4,
      REG_REVERSE_TICKS = 3'd5,
      REG_WAIT_TICKS    = 3'd6
   } reg_index_type;

   // Reset values of the registers
   localparam logic [COORD_W-1:0] CENTER_X_RST      = 16'd0;
   localparam logic [COORD_W-1:0] CENTER_Y_RST      = 16'd1600;
   localparam logic [AXIS_W-1:0]  SEMI_AXIS_X_RST   = 15'd416;
   localparam logic [AXIS_W-1:0]  SEMI_AXIS_Y_RST   = 15'd360;
   localparam logic [TICK_W-1:0]  BRAKE_TICKS_RST   = 16'd400;
   localparam logic [TICK_W-1:0]  REVERSE_TICKS_RST = 16'd5;
   localparam logic [TICK_W-1:0]  WAIT_TICKS_RST    = 16'd500;

   // Drive codes
   localparam logic [CODE_W-1:0] DRIVE_OFF     = 2'd0;
   localparam logic [CODE_W-1:0] DRIVE_BRAKE   = 2'd1;
   localparam logic [CODE_W-1:0] DRIVE_REVERSE = 2'd2;

   // Phase codes
   localparam logic [CODE_W-1:0] PHASE_IDLE    = 2'd0;
   localparam logic [CODE_W-1:0] PHASE_BRAKE   = 2'd1;
   localparam logic [CODE_W-1:0] PHASE_REVERSE = 2'd2;

   // Item kinds carried on tuser
   localparam logic OP_POSITION = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [AXIS_W-1:0]         semi_axis_x;
      logic [AXIS_W-1:0]         semi_axis_y;
      logic [TICK_W-1:0]         brake_ticks;
      logic [TICK_W-1:0]         reverse_ticks;
      logic [TICK_W-1:0]         wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] drive_code;
      logic [CODE_W-1:0] phase;
      logic              outside;
   } status_type;

endpackage

// File: hw/rtl/tbbs_csr.sv
// Configuration register file with an APB-style access port.
// Depends on tbbs_pkg for the register map and the cfg_type bundle.

module tbbs_csr
   import tbbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_CENTER_X:      cfg_in.center_x      = csr_pwdata[COORD_W-1:0];
            REG_CENTER_Y:      cfg_in.center_y      = csr_pwdata[COORD_W-1:0];
            REG_SEMI_AXIS_X:   cfg_in.semi_axis_x   = csr_pwdata[AXIS_W-1:0];
            REG_SEMI_AXIS_Y:   cfg_in.semi_axis_y   = csr_pwdata[AXIS_W-1:0];
            REG_BRAKE_TICKS:   cfg_in.brake_ticks   = csr_pwdata[TICK_W-1:0];
            REG_REVERSE_TICKS: cfg_in.reverse_ticks = csr_pwdata[TICK_W-1:0];
            REG_WAIT_TICKS:    cfg_in.wait_ticks    = csr_pwdata[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x      <= CENTER_X_RST;
         cfg_ff.center_y      <= CENTER_Y_RST;
         cfg_ff.semi_axis_x   <= SEMI_AXIS_X_RST;
         cfg_ff.semi_axis_y   <= SEMI_AXIS_Y_RST;
         cfg_ff.brake_ticks   <= BRAKE_TICKS_RST;
         cfg_ff.reverse_ticks <= REVERSE_TICKS_RST;
         cfg_ff.wait_ticks    <= WAIT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, zero extended
   always_comb begin
      case (idx)
         REG_CENTER_X:      csr_prdata = {{(CSR_DW-COORD_W){1'b0}}, cfg_ff.center_x};
         REG_CENTER_Y:      csr_prdata = {{(CSR_DW-COORD_W){1'b0}}, cfg_ff.center_y};
         REG_SEMI_AXIS_X:   csr_prdata = {{(CSR_DW-AXIS_W){1'b0}}, cfg_ff.semi_axis_x};
         REG_SEMI_AXIS_Y:   csr_prdata = {{(CSR_DW-AXIS_W){1'b0}}, cfg_ff.semi_axis_y};
         REG_BRAKE_TICKS:   csr_prdata = {{(CSR_DW-TICK_W){1'b0}}, cfg_ff.brake_ticks};
         REG_REVERSE_TICKS: csr_prdata = {{(CSR_DW-TICK_W){1'b0}}, cfg_ff.reverse_ticks};
         REG_WAIT_TICKS:    csr_prdata = {{(CSR_DW-TICK_W){1'b0}}, cfg_ff.wait_ticks};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/tbbs_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on tbbs_pkg for the operand and product widths.

module tbbs_mul
   import tbbs_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_W-1:0]  mul_a,
   input  logic [MUL_W-1:0]  mul_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hw/rtl/tbbs_ellipse.sv
// Ellipse boundary test: dx^2*b^2 + dy^2*a^2 >= a^2*b^2, exact integers.
// Sequences seven products through one tbbs_mul; depends on tbbs_pkg.

module tbbs_ellipse
   import tbbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] pos_x,
   input  logic signed [COORD_W-1:0] pos_y,
   input  cfg_type                   cfg,
   output logic                      done,
   output logic                      outside
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_A2   = 10'b00_0000_0010,
      ST_B2   = 10'b00_0000_0100,
      ST_DX2  = 10'b00_0000_1000,
      ST_DY2  = 10'b00_0001_0000,
      ST_T1   = 10'b00_0010_0000,
      ST_T2   = 10'b00_0100_0000,
      ST_AB   = 10'b00_1000_0000,
      ST_SUM  = 10'b01_0000_0000,
      ST_CMP  = 10'b10_0000_0000
   } ell_state_type;

   ell_state_type state_ff, state_in;

   logic [DIST_W-1:0]  dx_ff, dy_ff;
   logic [2*AXIS_W-1:0] a2_ff, b2_ff;
   logic [2*DIST_W-1:0] dx2_ff, dy2_ff;
   logic [SUM_W-2:0]   t1_ff, t2_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [4*AXIS_W-1:0] ab_ff;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  prod;
   logic signed [COORD_W:0] diff_x, diff_y;

   tbbs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Absolute distances from the center, 16 bits unsigned
   assign diff_x = {pos_x[COORD_W-1], pos_x} - {cfg.center_x[COORD_W-1], cfg.center_x};
   assign diff_y = {pos_y[COORD_W-1], pos_y} - {cfg.center_y[COORD_W-1], cfg.center_y};

   // Sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_A2 : ST_IDLE;
         ST_A2:   state_in = ST_B2;
         ST_B2:   state_in = ST_DX2;
         ST_DX2:  state_in = ST_DY2;
         ST_DY2:  state_in = ST_T1;
         ST_T1:   state_in = ST_T2;
         ST_T2:   state_in = ST_AB;
         ST_AB:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand select: each state from ST_A2 to ST_AB issues one product, the previous one lands
   always_comb begin
      case (state_ff)
         ST_A2: begin
            mul_a = {{(MUL_W-AXIS_W){1'b0}}, cfg.semi_axis_x};
            mul_b = {{(MUL_W-AXIS_W){1'b0}}, cfg.semi_axis_x};
         end
         ST_B2: begin
            mul_a = {{(MUL_W-AXIS_W){1'b0}}, cfg.semi_axis_y};
            mul_b = {{(MUL_W-AXIS_W){1'b0}}, cfg.semi_axis_y};
         end
         ST_DX2: begin
            mul_a = {{(MUL_W-DIST_W){1'b0}}, dx_ff};
            mul_b = {{(MUL_W-DIST_W){1'b0}}, dx_ff};
         end
         ST_DY2: begin
            mul_a = {{(MUL_W-DIST_W){1'b0}}, dy_ff};
            mul_b = {{(MUL_W-DIST_W){1'b0}}, dy_ff};
         end
         ST_T1: begin
            mul_a = dx2_ff;
            mul_b = {{(MUL_W-2*AXIS_W){1'b0}}, b2_ff};
         end
         ST_T2: begin
            mul_a = dy2_ff;
            mul_b = {{(MUL_W-2*AXIS_W){1'b0}}, a2_ff};
         end
         ST_AB: begin
            mul_a = {{(MUL_W-2*AXIS_W){1'b0}}, a2_ff};
            mul_b = {{(MUL_W-2*AXIS_W){1'b0}}, b2_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Operand and partial product registers
   always_ff @(posedge clock) begin
      if (start && (state_ff == ST_IDLE)) begin
         dx_ff <= diff_x[COORD_W] ? DIST_W'(-diff_x) : diff_x[DIST_W-1:0];
         dy_ff <= diff_y[COORD_W] ? DIST_W'(-diff_y) : diff_y[DIST_W-1:0];
      end
      if (state_ff == ST_B2)  a2_ff  <= prod[2*AXIS_W-1:0];
      if (state_ff == ST_DX2) b2_ff  <= prod[2*AXIS_W-1:0];
      if (state_ff == ST_DY2) dx2_ff <= prod[2*DIST_W-1:0];
      if (state_ff == ST_T1)  dy2_ff <= prod[2*DIST_W-1:0];
      if (state_ff == ST_T2)  t1_ff  <= prod[SUM_W-2:0];
      if (state_ff == ST_AB)  t2_ff  <= prod[SUM_W-2:0];
      if (state_ff == ST_SUM) begin
         ab_ff  <= prod[4*AXIS_W-1:0];
         sum_ff <= {1'b0, t1_ff} + {1'b0, t2_ff};
      end
   end

   assign done    = (state_ff == ST_CMP);
   assign outside = (sum_ff >= {{(SUM_W-4*AXIS_W){1'b0}}, ab_ff});

endmodule

// File: hw/rtl/tbbs_phase.sv
// Brake phase sequencer: idle-wait, brake, reverse, with a shared tick timer.
// Also holds the outside flag; depends on tbbs_pkg.

module tbbs_phase
   import tbbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick_en,
   input  logic       flag_en,
   input  logic       flag_value,
   input  cfg_type    cfg,
   output status_type status
);

   logic [CODE_W-1:0] phase_ff, phase_in;
   logic [CODE_W-1:0] drive_ff, drive_in;
   logic              entry_ff, entry_in;
   logic              wait_done_ff, wait_done_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic              outside_ff, outside_in;

   logic [TICK_W-1:0] elapsed_inc;
   logic [TICK_W-1:0] limit;
   logic              running;

   // Saturating timer step against the current phase limit
   assign elapsed_inc = (elapsed_ff != TICK_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;

   always_comb begin
      case (phase_ff)
         PHASE_BRAKE:   limit = cfg.brake_ticks;
         PHASE_REVERSE: limit = cfg.reverse_ticks;
         default:       limit = cfg.wait_ticks;
      endcase
   end

   assign running = (elapsed_inc < limit);

   // Tick update
   always_comb begin
      phase_in     = phase_ff;
      drive_in     = drive_ff;
      entry_in     = entry_ff;
      wait_done_in = wait_done_ff;
      elapsed_in   = elapsed_ff;
      outside_in   = flag_en ? flag_value : outside_ff;
      if (tick_en) begin
         case (phase_ff)
            PHASE_BRAKE: begin
               if (entry_ff) begin
                  elapsed_in = '0;
                  entry_in   = 1'b0;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (running) begin
                     drive_in = DRIVE_BRAKE;
                  end else begin
                     phase_in = PHASE_REVERSE;
                     entry_in = 1'b1;
                  end
               end
            end
            PHASE_REVERSE: begin
               if (entry_ff) begin
                  elapsed_in = '0;
                  entry_in   = 1'b0;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (running) begin
                     drive_in = DRIVE_REVERSE;
                  end else begin
                     phase_in     = PHASE_IDLE;
                     entry_in     = 1'b1;
                     wait_done_in = 1'b0;
                  end
               end
            end
            default: begin
               // idle, and the unused code behaves as idle
               phase_in = PHASE_IDLE;
               if (entry_ff) begin
                  elapsed_in = '0;
                  entry_in   = 1'b0;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (running) begin
                     drive_in = DRIVE_OFF;
                  end else begin
                     wait_done_in = 1'b1;
                  end
               end
               if (wait_done_in) begin
                  if (outside_ff) begin
                     phase_in = PHASE_BRAKE;
                     entry_in = 1'b1;
                  end else begin
                     drive_in = DRIVE_OFF;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         drive_ff     <= DRIVE_OFF;
         entry_ff     <= 1'b1;
         wait_done_ff <= 1'b0;
         elapsed_ff   <= '0;
         outside_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         drive_ff     <= drive_in;
         entry_ff     <= entry_in;
         wait_done_ff <= wait_done_in;
         elapsed_ff   <= elapsed_in;
         outside_ff   <= outside_in;
      end
   end

   assign status.drive_code = drive_ff;
   assign status.phase      = phase_ff;
   assign status.outside    = outside_ff;

endmodule

// File: hw/rtl/timed_boundary_brake_sequencer_unit.sv
// Timed boundary brake sequencer, top level: stream handshake, item control,
// result register. Depends on tbbs_pkg, tbbs_csr, tbbs_ellipse, tbbs_phase.
//
// The block takes one item at a time. A control tick (tuser = 1) updates the
// brake sequencer, whose registered status then goes to the result register.
// A position sample (tuser = 0) runs the ellipse test through a single shared
// 32x32 multiplier, seven products in sequence plus an add and a compare,
// before its result is loaded. Each item gives exactly one result, held in an
// output register; the next item is accepted while that result still waits
// to be taken, and the block stalls only when a new result finds the register
// still full. The user must write registers through the APB-style port only
// while no item is in flight; the block itself does not enforce it.

module timed_boundary_brake_sequencer_unit
   import tbbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // [15:0] pos_x, [31:16] pos_y
   input  logic              req_tuser,   // [0] opcode: 0 position, 1 tick
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [1:0] drive_code, [3:2] phase, [4] outside
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      CTL_IDLE = 3'b001,
      CTL_CALC = 3'b010,
      CTL_PUSH = 3'b100
   } ctl_state_type;

   ctl_state_type ctl_ff, ctl_in;

   cfg_type    cfg;
   status_type status;
   logic       req_xfer;
   logic       ell_start, ell_done, ell_outside;
   logic       tick_en;
   logic       rsp_load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   tbbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbbs_ellipse u_ellipse (
      .clock   (clock),
      .reset   (reset),
      .start   (ell_start),
      .pos_x   (req_tdata[COORD_W-1:0]),
      .pos_y   (req_tdata[2*COORD_W-1:COORD_W]),
      .cfg     (cfg),
      .done    (ell_done),
      .outside (ell_outside)
   );

   tbbs_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .flag_en    (ell_done),
      .flag_value (ell_outside),
      .cfg        (cfg),
      .status     (status)
   );

   // Item dispatch
   assign req_tready = (ctl_ff == CTL_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign ell_start  = req_xfer & (req_tuser == OP_POSITION);
   assign tick_en    = req_xfer & (req_tuser == OP_TICK);
   assign rsp_load   = (ctl_ff == CTL_PUSH) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      case (ctl_ff)
         CTL_IDLE: begin
            if (ell_start)    ctl_in = CTL_CALC;
            else if (tick_en) ctl_in = CTL_PUSH;
            else              ctl_in = CTL_IDLE;
         end
         CTL_CALC: ctl_in = ell_done ? CTL_PUSH : CTL_CALC;
         CTL_PUSH: ctl_in = rsp_load ? CTL_IDLE : CTL_PUSH;
         default:  ctl_in = CTL_IDLE;
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DW-2*CODE_W-1){1'b0}}, status.outside,
                         status.phase, status.drive_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
